@@ sv/wsd_pkg.sv @@
// Package: shared types and constants of the WebSocket frame deframer.
package wsd_pkg;

  // Parse phase of the frame header walker
  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  // 7-bit length codes that announce an extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Extended length field sizes in bytes
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  // Default depth of the queue between front and back
  localparam int FIFO_DEPTH_DEF = 2;

  // One queued result: raw byte plus the key byte that unmasks it
  typedef struct packed {
    logic [7:0] raw;
    logic [7:0] key;
    logic       has_data;
    logic [3:0] opcode;
    logic       fin;
    logic       rsv1;
    logic       rsv2;
    logic       rsv3;
    logic       was_masked;
    logic       last;
  } wsd_entry_t;

endpackage

@@ sv/wsd_in_if.sv @@
// Interface: raw frame byte channel (valid/ready).
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

@@ sv/wsd_out_if.sv @@
// Interface: unmasked payload result channel (valid/ready).
interface wsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_data;
  logic [3:0] opcode;
  logic       fin;
  logic       rsv1;
  logic       rsv2;
  logic       rsv3;
  logic       was_masked;
  logic       last_of_frame;

  modport source (output valid, output data_byte, output has_data, output opcode,
                  output fin, output rsv1, output rsv2, output rsv3,
                  output was_masked, output last_of_frame, input ready);
  modport sink   (input valid, input data_byte, input has_data, input opcode,
                  input fin, input rsv1, input rsv2, input rsv3,
                  input was_masked, input last_of_frame, output ready);
endinterface

@@ sv/wsd_front.sv @@
// Front end: accepts frame bytes, walks the header and queues result entries.
module wsd_front (
  input  logic                clk,
  input  logic                rst_n,
  wsd_in_if.sink              in_ch,
  output logic                push,
  output wsd_pkg::wsd_entry_t push_entry,
  input  logic                fifo_full
);
  import wsd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  hdr0_r, hdr0_nxt;
  logic        mask_r, mask_nxt;
  logic [3:0]  ext_r, ext_nxt;
  logic [63:0] pl_r, pl_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  kpos_r, kpos_nxt;

  logic        in_acc;
  logic [7:0]  b;
  logic [6:0]  len7;
  logic        pl_zero;
  logic [7:0]  kb;

  assign in_ch.ready = !fifo_full;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;
  assign len7        = b[6:0];
  assign pl_zero     = (pl_nxt == 64'd0);

  // Current key byte; byte 0 of the key sits in the top bits
  always_comb begin
    case (kpos_r)
      2'd0:    kb = key_r[31:24];
      2'd1:    kb = key_r[23:16];
      2'd2:    kb = key_r[15:8];
      2'd3:    kb = key_r[7:0];
      default: kb = key_r[31:24];
    endcase
  end

  // Header, length and key datapath
  always_comb begin
    hdr0_nxt = hdr0_r;
    mask_nxt = mask_r;
    ext_nxt  = ext_r;
    pl_nxt   = pl_r;
    key_nxt  = key_r;
    kpos_nxt = kpos_r;
    if (in_acc) begin
      case (phase_r)
        PH_HDR0: begin
          hdr0_nxt = b;
        end
        PH_HDR1: begin
          mask_nxt = b[7];
          kpos_nxt = 2'd0;
          if (len7 == LEN_EXT16) begin
            ext_nxt = EXT16_BYTES;
            pl_nxt  = 64'd0;
          end else if (len7 == LEN_EXT64) begin
            ext_nxt = EXT64_BYTES;
            pl_nxt  = 64'd0;
          end else begin
            pl_nxt = {57'd0, len7};
          end
        end
        PH_EXTLEN: begin
          pl_nxt  = {pl_r[55:0], b};
          ext_nxt = ext_r - 4'd1;
        end
        PH_KEY: begin
          key_nxt  = {key_r[23:0], b};
          kpos_nxt = kpos_r + 2'd1;
        end
        PH_PAYLOAD: begin
          pl_nxt = pl_r - 64'd1;
          if (mask_r) kpos_nxt = kpos_r + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_acc) begin
      case (phase_r)
        PH_HDR0: phase_nxt = PH_HDR1;
        PH_HDR1: begin
          if (len7 == LEN_EXT16 || len7 == LEN_EXT64) phase_nxt = PH_EXTLEN;
          else if (b[7])                               phase_nxt = PH_KEY;
          else if (pl_zero)                            phase_nxt = PH_HDR0;
          else                                         phase_nxt = PH_PAYLOAD;
        end
        PH_EXTLEN: begin
          if (ext_nxt == 4'd0) begin
            if (mask_r)       phase_nxt = PH_KEY;
            else if (pl_zero) phase_nxt = PH_HDR0;
            else              phase_nxt = PH_PAYLOAD;
          end
        end
        PH_KEY: begin
          if (kpos_nxt == 2'd0) phase_nxt = pl_zero ? PH_HDR0 : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (pl_zero) phase_nxt = PH_HDR0;
        end
        default: phase_nxt = PH_HDR0;
      endcase
    end
  end

  // Queue writes: payload bytes and the empty-frame marker
  always_comb begin
    push                  = 1'b0;
    push_entry.raw        = 8'd0;
    push_entry.key        = 8'd0;
    push_entry.has_data   = 1'b0;
    push_entry.opcode     = hdr0_r[3:0];
    push_entry.fin        = hdr0_r[7];
    push_entry.rsv1       = hdr0_r[6];
    push_entry.rsv2       = hdr0_r[5];
    push_entry.rsv3       = hdr0_r[4];
    push_entry.was_masked = mask_nxt;
    push_entry.last       = 1'b1;
    if (in_acc) begin
      case (phase_r)
        PH_HDR1: begin
          push = !(len7 == LEN_EXT16 || len7 == LEN_EXT64) && !b[7] && pl_zero;
        end
        PH_EXTLEN: begin
          push = (ext_nxt == 4'd0) && !mask_r && pl_zero;
        end
        PH_KEY: begin
          push = (kpos_nxt == 2'd0) && pl_zero;
        end
        PH_PAYLOAD: begin
          push                = 1'b1;
          push_entry.raw      = b;
          push_entry.key      = mask_r ? kb : 8'd0;
          push_entry.has_data = 1'b1;
          push_entry.last     = pl_zero;
        end
        default: push = 1'b0;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      mask_r  <= 1'b0;
      ext_r   <= 4'd0;
      pl_r    <= 64'd0;
      kpos_r  <= 2'd0;
    end else begin
      phase_r <= phase_nxt;
      mask_r  <= mask_nxt;
      ext_r   <= ext_nxt;
      pl_r    <= pl_nxt;
      kpos_r  <= kpos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr0_r <= hdr0_nxt;
    key_r  <= key_nxt;
  end

  // Payload bytes only ever get queued in the payload phase or as a marker
  a_no_push_hdr0: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HDR0) |-> !push)
    else $error("queue write while waiting for first header byte");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !fifo_full)
    else $error("queue write while queue full");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_entry.last) |=> (phase_r == PH_HDR0))
    else $error("frame end not followed by header phase");

endmodule

@@ sv/wsd_fifo.sv @@
// Queue: small register FIFO that decouples the parser from the output stage.
module wsd_fifo #(
  parameter int DEPTH = wsd_pkg::FIFO_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  wsd_pkg::wsd_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output wsd_pkg::wsd_entry_t pop_entry
);
  import wsd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  wsd_entry_t    mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == FULL_CNT);
  assign empty     = (cnt_r == '0);
  assign pop_entry = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("queue fill count out of range");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue fill count lost a write");

endmodule

@@ sv/wsd_back.sv @@
// Back end: unmasks queued bytes into the registered result stage.
module wsd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                empty,
  input  wsd_pkg::wsd_entry_t pop_entry,
  output logic                pop,
  wsd_out_if.source           out_ch
);
  import wsd_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       has_r, fin_r, rsv1_r, rsv2_r, rsv3_r, masked_r, last_r;
  logic [3:0] opcode_r;

  // Refill the output stage when it is empty or being taken
  assign pop = !empty && (!valid_r || out_ch.ready);

  always_comb begin
    valid_nxt = valid_r;
    if (pop)               valid_nxt = 1'b1;
    else if (out_ch.ready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  // Result payload; key byte is zero for unmasked frames and markers
  always_ff @(posedge clk) begin
    if (pop) begin
      data_r   <= pop_entry.raw ^ pop_entry.key;
      has_r    <= pop_entry.has_data;
      opcode_r <= pop_entry.opcode;
      fin_r    <= pop_entry.fin;
      rsv1_r   <= pop_entry.rsv1;
      rsv2_r   <= pop_entry.rsv2;
      rsv3_r   <= pop_entry.rsv3;
      masked_r <= pop_entry.was_masked;
      last_r   <= pop_entry.last;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.data_byte     = data_r;
  assign out_ch.has_data      = has_r;
  assign out_ch.opcode        = opcode_r;
  assign out_ch.fin           = fin_r;
  assign out_ch.rsv1          = rsv1_r;
  assign out_ch.rsv2          = rsv2_r;
  assign out_ch.rsv3          = rsv3_r;
  assign out_ch.was_masked    = masked_r;
  assign out_ch.last_of_frame = last_r;

  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !has_r) |-> (last_r && data_r == 8'd0))
    else $error("empty-frame marker not flagged last or carries data");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_ch.ready) |=> (valid_r && $stable(data_r) && $stable(last_r)))
    else $error("output stage changed while stalled");

  a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> valid_r)
    else $error("queue read did not load output stage");

endmodule

@@ sv/websocket_frame_deframer_top.sv @@
// Top level: WebSocket frame deframer, header parser front, queue and unmask stage.
// A payload byte enters the queue at the edge that accepts it, then loads into the
// registered output stage once that stage is empty or being taken. Throughput: one
// input byte per cycle while the queue is not full, header bytes included; the output
// stage registers one result; the queue absorbs output stalls of FIFO_DEPTH results.
// Reset (rst_n low, synchronous) returns the parser to the first header byte and
// empties the queue and the output stage.
module websocket_frame_deframer_top #(
  parameter int FIFO_DEPTH = wsd_pkg::FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  wsd_in_if.sink     in_ch,
  wsd_out_if.source  out_ch
);
  import wsd_pkg::*;

  logic       push, full, pop, empty;
  wsd_entry_t push_entry, pop_entry;

  wsd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push       (push),
    .push_entry (push_entry),
    .fifo_full  (full)
  );

  wsd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .empty      (empty),
    .pop_entry  (pop_entry)
  );

  wsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop_entry  (pop_entry),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
